@@ rtl/lz4d_pkg.sv @@
// shared types and constants of the lz4 block decompressor
`default_nettype none

package lz4d_pkg;

	// field and counter widths
	localparam int LEN_W   = 24;
	localparam int CNT_W   = 32;
	localparam int HIST_AW = 16;

	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [HIST_AW-1:0] haddr_t;

	// configuration register indexes
	localparam logic REG_BLOCK_LENGTH    = 1'b0;
	localparam logic REG_OUTPUT_CAPACITY = 1'b1;

	// request operation codes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PUSH  = 2'd1,
		OP_PULL  = 2'd2
	} lz4d_op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DECODING = 2'd0,
		ST_DONE     = 2'd1,
		ST_ERROR    = 2'd2
	} lz4d_status_t;

	// parser phases
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_TOKEN    = 4'd1,
		PH_LITEXT   = 4'd2,
		PH_LITERAL  = 4'd3,
		PH_OFF0     = 4'd4,
		PH_OFF1     = 4'd5,
		PH_MATCHEXT = 4'd6,
		PH_MATCH    = 4'd7,
		PH_ZEROCAP  = 4'd8,
		PH_DONE     = 4'd9,
		PH_ERROR    = 4'd10
	} lz4d_phase_t;

	// per-request byte production info from the parser
	typedef struct packed {
		logic   taken;
		logic   emit;
		logic   is_pull;
		logic   [7:0] lit_byte;
		haddr_t rd_addr;
		haddr_t wr_addr;
	} lz4d_emit_t;

	// status fields shown with each result
	typedef struct packed {
		logic         match_pending;
		lz4d_status_t status;
		len_t         out_count;
		len_t         error_position;
	} lz4d_stat_t;

endpackage

`default_nettype wire

@@ rtl/lz4d_parser.sv @@
// lz4 sequence parser: token, lengths, offsets and the safe-decoder checks
`default_nettype none

module lz4d_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [1:0]          op_code,
	input  wire logic [7:0]          data_byte,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire lz4d_pkg::len_t      cfg_data,
	output lz4d_pkg::lz4d_emit_t     emit,
	output lz4d_pkg::lz4d_stat_t     stat
);

	lz4d_pkg::lz4d_op_t    op;
	lz4d_pkg::lz4d_phase_t phase_q, phase_d;

	lz4d_pkg::len_t   blen_q, ocap_q, in_limit_q, out_limit_q;
	lz4d_pkg::len_t   consumed_q, produced_q, error_at_q;
	lz4d_pkg::cnt_t   lit_left_q, match_left_q;
	logic [3:0]       nibble_q;
	lz4d_pkg::haddr_t dist_q;

	lz4d_pkg::len_t   consumed_inc, rem_in, rem_in_inc, rem_out, fail_pos;
	logic [lz4d_pkg::CNT_W:0]   lit_sum, ml_sum;
	logic [lz4d_pkg::CNT_W+1:0] fm_sum;
	lz4d_pkg::cnt_t   ll_new, fm_base;
	lz4d_pkg::haddr_t dist_new;
	logic             lit_bad, fm_bad, dist_bad, al_done, al_short;
	logic             push_phase, taken, fail, finishing;

	assign op = lz4d_pkg::lz4d_op_t'(op_code);

	// shared arithmetic for the checks
	always_comb begin
		consumed_inc = consumed_q + lz4d_pkg::len_t'(1);
		rem_in       = in_limit_q - consumed_q;
		rem_in_inc   = in_limit_q - consumed_inc;
		rem_out      = out_limit_q - produced_q;
		lit_sum      = {1'b0, lit_left_q} + (lz4d_pkg::CNT_W+1)'(data_byte);
		ml_sum       = {1'b0, match_left_q} + (lz4d_pkg::CNT_W+1)'(data_byte);
		ll_new       = (phase_q == lz4d_pkg::PH_TOKEN) ?
			lz4d_pkg::cnt_t'(data_byte[7:4]) : lit_sum[lz4d_pkg::CNT_W-1:0];
		lit_bad      = (ll_new > lz4d_pkg::cnt_t'(rem_in_inc)) ||
			(ll_new > lz4d_pkg::cnt_t'(rem_out));
		al_done      = (consumed_inc == in_limit_q);
		al_short     = (rem_in_inc < lz4d_pkg::len_t'(8));
		fm_base      = (phase_q == lz4d_pkg::PH_OFF1) ?
			lz4d_pkg::cnt_t'(nibble_q) : ml_sum[lz4d_pkg::CNT_W-1:0];
		// match plus minimum length must leave the end-of-block margin
		fm_sum       = (lz4d_pkg::CNT_W+2)'(fm_base) + (lz4d_pkg::CNT_W+2)'(9);
		fm_bad       = fm_sum > (lz4d_pkg::CNT_W+2)'(rem_out);
		dist_new     = {data_byte, dist_q[7:0]};
		dist_bad     = (dist_new == '0) || (lz4d_pkg::len_t'(dist_new) > produced_q);
		push_phase   = phase_q inside {lz4d_pkg::PH_TOKEN, lz4d_pkg::PH_LITEXT,
			lz4d_pkg::PH_LITERAL, lz4d_pkg::PH_OFF0, lz4d_pkg::PH_OFF1,
			lz4d_pkg::PH_MATCHEXT, lz4d_pkg::PH_ZEROCAP};
		finishing    = ((phase_q == lz4d_pkg::PH_OFF1) && (nibble_q != 4'hF)) ||
			((phase_q == lz4d_pkg::PH_MATCHEXT) && (data_byte != 8'hFF));
	end

	// request taken or refused
	always_comb begin
		case (op)
			lz4d_pkg::OP_START: taken = 1'b1;
			lz4d_pkg::OP_PUSH:  taken = push_phase;
			lz4d_pkg::OP_PULL:  taken = (phase_q == lz4d_pkg::PH_MATCH);
			default:            taken = 1'b0;
		endcase
	end

	// next phase and failure detection
	always_comb begin
		phase_d  = phase_q;
		fail     = 1'b0;
		fail_pos = consumed_q;
		if (accept) begin
			case (op)
				lz4d_pkg::OP_START: begin
					fail_pos = '0;
					if (ocap_q == '0) begin
						if (blen_q == lz4d_pkg::len_t'(1)) phase_d = lz4d_pkg::PH_ZEROCAP;
						else fail = 1'b1;
					end else if (blen_q == '0) begin
						fail = 1'b1;
					end else begin
						phase_d = lz4d_pkg::PH_TOKEN;
					end
				end
				lz4d_pkg::OP_PUSH: begin
					case (phase_q)
						lz4d_pkg::PH_ZEROCAP: begin
							fail_pos = '0;
							if (data_byte == 8'd0) phase_d = lz4d_pkg::PH_DONE;
							else fail = 1'b1;
						end
						lz4d_pkg::PH_TOKEN: begin
							if (rem_in == '0) begin
								fail = 1'b1;
							end else if (data_byte[7:4] == 4'hF) begin
								phase_d = lz4d_pkg::PH_LITEXT;
							end else if (lit_bad) begin
								fail     = 1'b1;
								fail_pos = consumed_inc;
							end else if (ll_new == '0) begin
								fail_pos = consumed_inc;
								if (al_done) phase_d = lz4d_pkg::PH_DONE;
								else if (al_short) fail = 1'b1;
								else phase_d = lz4d_pkg::PH_OFF0;
							end else begin
								phase_d = lz4d_pkg::PH_LITERAL;
							end
						end
						lz4d_pkg::PH_LITEXT: begin
							if (rem_in == '0) begin
								fail = 1'b1;
							end else if (lit_sum[lz4d_pkg::CNT_W]) begin
								fail     = 1'b1;
								fail_pos = consumed_inc;
							end else if (data_byte != 8'hFF) begin
								fail_pos = consumed_inc;
								if (lit_bad) fail = 1'b1;
								else phase_d = lz4d_pkg::PH_LITERAL;
							end
						end
						lz4d_pkg::PH_LITERAL: begin
							fail_pos = consumed_inc;
							if (lit_left_q == lz4d_pkg::cnt_t'(1)) begin
								if (al_done) phase_d = lz4d_pkg::PH_DONE;
								else if (al_short) fail = 1'b1;
								else phase_d = lz4d_pkg::PH_OFF0;
							end
						end
						lz4d_pkg::PH_OFF0: phase_d = lz4d_pkg::PH_OFF1;
						lz4d_pkg::PH_OFF1: begin
							fail_pos = consumed_inc;
							if (dist_bad) fail = 1'b1;
							else if (nibble_q == 4'hF) phase_d = lz4d_pkg::PH_MATCHEXT;
							else if (fm_bad) fail = 1'b1;
							else phase_d = lz4d_pkg::PH_MATCH;
						end
						lz4d_pkg::PH_MATCHEXT: begin
							if (rem_in <= lz4d_pkg::len_t'(6)) begin
								fail = 1'b1;
							end else begin
								fail_pos = consumed_inc;
								if (ml_sum[lz4d_pkg::CNT_W]) fail = 1'b1;
								else if (data_byte != 8'hFF) begin
									if (fm_bad) fail = 1'b1;
									else phase_d = lz4d_pkg::PH_MATCH;
								end
							end
						end
						default: ;
					endcase
				end
				lz4d_pkg::OP_PULL: begin
					if ((phase_q == lz4d_pkg::PH_MATCH) &&
						(match_left_q == lz4d_pkg::cnt_t'(1))) begin
						phase_d = lz4d_pkg::PH_TOKEN;
					end
				end
				default: ;
			endcase
		end
		if (fail) phase_d = lz4d_pkg::PH_ERROR;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= '0;
			ocap_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == lz4d_pkg::REG_BLOCK_LENGTH) blen_q <= cfg_data;
			if (cfg_index == lz4d_pkg::REG_OUTPUT_CAPACITY) ocap_q <= cfg_data;
		end
	end

	// block state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lz4d_pkg::PH_IDLE;
			in_limit_q   <= '0;
			out_limit_q  <= '0;
			consumed_q   <= '0;
			produced_q   <= '0;
			error_at_q   <= '0;
			lit_left_q   <= '0;
			match_left_q <= '0;
			nibble_q     <= '0;
			dist_q       <= '0;
		end else if (accept && taken) begin
			phase_q <= phase_d;
			if (fail) error_at_q <= fail_pos;
			case (op)
				lz4d_pkg::OP_START: begin
					in_limit_q   <= blen_q;
					out_limit_q  <= ocap_q;
					consumed_q   <= '0;
					produced_q   <= '0;
					lit_left_q   <= '0;
					match_left_q <= '0;
					nibble_q     <= '0;
					dist_q       <= '0;
					if (!fail) error_at_q <= '0;
				end
				lz4d_pkg::OP_PUSH: begin
					consumed_q <= consumed_inc;
					case (phase_q)
						lz4d_pkg::PH_TOKEN: begin
							lit_left_q <= ll_new;
							nibble_q   <= data_byte[3:0];
						end
						lz4d_pkg::PH_LITEXT: lit_left_q <= ll_new;
						lz4d_pkg::PH_LITERAL: begin
							produced_q <= produced_q + lz4d_pkg::len_t'(1);
							lit_left_q <= lit_left_q - lz4d_pkg::cnt_t'(1);
						end
						lz4d_pkg::PH_OFF0: dist_q <= lz4d_pkg::haddr_t'(data_byte);
						lz4d_pkg::PH_OFF1, lz4d_pkg::PH_MATCHEXT: begin
							if (phase_q == lz4d_pkg::PH_OFF1) dist_q <= dist_new;
							match_left_q <= finishing ? fm_base + lz4d_pkg::cnt_t'(4) : fm_base;
						end
						default: ;
					endcase
				end
				lz4d_pkg::OP_PULL: begin
					produced_q   <= produced_q + lz4d_pkg::len_t'(1);
					match_left_q <= match_left_q - lz4d_pkg::cnt_t'(1);
				end
				default: ;
			endcase
		end
	end

	// byte production info and status fields
	always_comb begin
		emit.taken    = taken;
		emit.is_pull  = (op == lz4d_pkg::OP_PULL);
		emit.emit     = taken && (emit.is_pull ||
			((op == lz4d_pkg::OP_PUSH) && (phase_q == lz4d_pkg::PH_LITERAL)));
		emit.lit_byte = data_byte;
		emit.wr_addr  = produced_q[lz4d_pkg::HIST_AW-1:0];
		emit.rd_addr  = produced_q[lz4d_pkg::HIST_AW-1:0] - dist_q;

		stat.match_pending  = (phase_q == lz4d_pkg::PH_MATCH);
		stat.out_count      = produced_q;
		stat.error_position = (phase_q == lz4d_pkg::PH_ERROR) ? error_at_q : '0;
		case (phase_q)
			lz4d_pkg::PH_DONE:  stat.status = lz4d_pkg::ST_DONE;
			lz4d_pkg::PH_ERROR: stat.status = lz4d_pkg::ST_ERROR;
			default:            stat.status = lz4d_pkg::ST_DECODING;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/lz4_block_decompressor.sv @@
// top level of the lz4 block decompressor: parser, history memory, result register
`default_nettype none

// Decodes one dictionary-free LZ4 block fed one compressed byte per request and
// returns exactly one result per request. A request is taken in any cycle where
// the result register is empty or being drained, so the block sustains one
// request per cycle: one token, literal, offset or match pull each clock. Match
// bytes come from a 64 KiB history memory with a registered read;
// the byte written by the request just before is forwarded, so a match at
// distance one also streams at full rate. Results wait in a single output
// register; the input stalls only while that register is full and not taken.
// The history memory needs no clearing after reset.
module lz4_block_decompressor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic [1:0]  s_tuser,   // operation
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // out_byte, out_count, error_position
	output logic [4:0]       m_tuser,   // accepted, out_valid, match_pending, status
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int HistDepth = 1 << lz4d_pkg::HIST_AW;

	lz4d_pkg::lz4d_emit_t emit;
	lz4d_pkg::lz4d_stat_t stat;

	logic             s_accept, m_tvalid_q, wr_pend_q, fwd;
	logic             taken_s2, valid_s2, from_mem_s2;
	logic [7:0]       byte_s2, rd_data_q, out_byte;
	lz4d_pkg::haddr_t wr_addr_s2;
	logic [7:0]       hist_mem [HistDepth];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	lz4d_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.op_code   (s_tuser),
		.data_byte (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.emit      (emit),
		.stat      (stat)
	);

	// byte shown with the current result
	assign out_byte = from_mem_s2 ? rd_data_q : byte_s2;

	// the previous request writes this cycle at the address about to be read
	assign fwd = wr_pend_q && emit.is_pull && (emit.rd_addr == wr_addr_s2);

	// history memory: read on request, write in the cycle after
	always_ff @(posedge clk) begin
		if (s_accept) rd_data_q <= hist_mem[emit.rd_addr];
		if (wr_pend_q) hist_mem[wr_addr_s2] <= out_byte;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			taken_s2    <= emit.taken;
			valid_s2    <= emit.emit;
			from_mem_s2 <= emit.emit && emit.is_pull && !fwd;
			wr_addr_s2  <= emit.wr_addr;
			if (!emit.emit) byte_s2 <= 8'd0;
			else if (emit.is_pull) byte_s2 <= out_byte;
			else byte_s2 <= emit.lit_byte;
		end
	end

	// result valid and pending history write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			wr_pend_q  <= 1'b0;
		end else begin
			wr_pend_q <= s_accept && emit.emit;
			if (s_accept) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {stat.error_position, stat.out_count, out_byte};
	assign m_tuser  = {stat.status, stat.match_pending, valid_s2, taken_s2};

endmodule

`default_nettype wire

@@ rtl/lz4d_checker.sv @@
// port-level checks of the lz4 block decompressor and their binding
`default_nettype none

module lz4d_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	// a refused request never carries a byte
	a_refused_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tuser[1] && (m_tdata[7:0] == 8'd0))
		else $error("refused request shows an output byte");

	// an error never leaves a match pending
	a_error_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[4:3] == lz4d_pkg::ST_ERROR) |-> !m_tuser[2])
		else $error("match pending in error status");

	// an error position is shown only with error status
	a_error_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[55:32] != 24'd0) |-> (m_tuser[4:3] == lz4d_pkg::ST_ERROR))
		else $error("error position without error status");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind lz4_block_decompressor lz4d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/tb_lz4_block_decompressor.sv @@
// testbench for the lz4 block decompressor: directed and random blocks against a decoder model
module tb_lz4_block_decompressor;
	import lz4d_pkg::*;

	localparam logic [1:0]  OP_BAD       = 2'd3;
	localparam int          CYCLE_LIMIT  = 40000;
	localparam int          HOLD_CYCLES  = 250;
	localparam int          TAIL_CYCLES  = 6;
	localparam logic [3:0]  NIB_EXT      = 4'hF;
	localparam logic [7:0]  EXT_MORE     = 8'hFF;
	localparam logic [31:0] MIN_MATCH    = 32'd4;
	localparam logic [31:0] MATCH_ROOM   = 32'd5;   // output room kept after a match
	localparam logic [31:0] OFFSET_TAIL  = 32'd8;   // input left after literals before an offset
	localparam logic [31:0] EXT_TAIL     = 32'd6;   // input left before a match extension
	localparam logic [31:0] WORD_MAX     = 32'hFFFF_FFFF;
	localparam logic [23:0] LEN_MAX      = 24'hFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [1:0]  s_tuser = OP_START;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [23:0] cfg_data = 24'd0;

	lz4_block_decompressor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct packed {
		logic         accepted;
		logic         out_valid;
		logic [7:0]   out_byte;
		logic         match_pending;
		lz4d_status_t status;
		len_t         out_count;
		len_t         error_position;
	} dec_result_t;

	dec_result_t decode_results_q[$];
	logic [7:0]  blk_bytes[$];
	int          mismatches = 0;
	int          work_items = 0;
	int          cycle_count = 0;
	logic        gaps_on = 1'b1;
	int          hold_asked = 0;
	int          hold_served;
	int          hold_left;

	// decoder model state
	lz4d_phase_t dec_phase = PH_IDLE;
	logic [31:0] tok_match = '0;
	logic [31:0] lit_left = '0;
	logic [31:0] mlen_left = '0;
	logic [31:0] match_dist = '0;
	logic [31:0] n_in = '0;
	logic [31:0] n_out = '0;
	logic [31:0] err_pos = '0;
	logic [31:0] lim_in = '0;
	logic [31:0] lim_out = '0;
	logic [23:0] cfg_len = '0;
	logic [23:0] cfg_cap = '0;
	logic [7:0]  history_mem [0:65535];

	function automatic void flag_error(logic [31:0] pos);
		err_pos = pos & {8'd0, LEN_MAX};
		dec_phase = PH_ERROR;
	endfunction

	function automatic void store_byte(logic [7:0] b);
		history_mem[n_out[15:0]] = b;
		n_out = (n_out + 32'd1) & {8'd0, LEN_MAX};
	endfunction

	// literal run over: block end, or an offset must follow with enough input left
	function automatic void end_literal_run();
		if (n_in == lim_in)
			dec_phase = PH_DONE;
		else if (lim_in - n_in < OFFSET_TAIL)
			flag_error(n_in);
		else
			dec_phase = PH_OFF0;
	endfunction

	function automatic void start_literal_run();
		if (lit_left > lim_in - n_in || lit_left > lim_out - n_out)
			flag_error(n_in);
		else if (lit_left == 0)
			end_literal_run();
		else
			dec_phase = PH_LITERAL;
	endfunction

	function automatic void arm_match();
		logic [31:0] room;
		if (mlen_left > WORD_MAX - MIN_MATCH) begin
			flag_error(n_in);
			return;
		end
		mlen_left += MIN_MATCH;
		room = lim_out - n_out;
		if (mlen_left > room || room - mlen_left < MATCH_ROOM)
			flag_error(n_in);
		else
			dec_phase = PH_MATCH;
	endfunction

	// expected result of one request, advancing the model
	function automatic dec_result_t decode_request(logic [1:0] op, logic [7:0] b);
		dec_result_t r;
		haddr_t rd;
		r = '0;
		if (op == OP_START) begin
			r.accepted = 1'b1;
			lim_in = {8'd0, cfg_len};
			lim_out = {8'd0, cfg_cap};
			tok_match = '0;
			lit_left = '0;
			mlen_left = '0;
			match_dist = '0;
			n_in = '0;
			n_out = '0;
			err_pos = '0;
			if (lim_out == 0) begin
				if (lim_in == 1)
					dec_phase = PH_ZEROCAP;
				else
					flag_error(32'd0);
			end else if (lim_in == 0) begin
				flag_error(32'd0);
			end else begin
				dec_phase = PH_TOKEN;
			end
		end else if (op == OP_PUSH && dec_phase inside {PH_TOKEN, PH_LITEXT, PH_LITERAL,
				PH_OFF0, PH_OFF1, PH_MATCHEXT, PH_ZEROCAP}) begin
			r.accepted = 1'b1;
			case (dec_phase)
				PH_ZEROCAP: begin
					n_in = 32'd1;
					if (b == 8'h00)
						dec_phase = PH_DONE;
					else
						flag_error(32'd0);
				end
				PH_TOKEN: begin
					if (n_in >= lim_in) begin
						flag_error(n_in);
					end else begin
						n_in++;
						lit_left = {28'd0, b[7:4]};
						tok_match = {28'd0, b[3:0]};
						if (b[7:4] == NIB_EXT)
							dec_phase = PH_LITEXT;
						else
							start_literal_run();
					end
				end
				PH_LITEXT: begin
					if (n_in >= lim_in) begin
						flag_error(n_in);
					end else begin
						n_in++;
						if (lit_left > WORD_MAX - b) begin
							flag_error(n_in);
						end else begin
							lit_left += b;
							if (b != EXT_MORE)
								start_literal_run();
						end
					end
				end
				PH_LITERAL: begin
					n_in++;
					store_byte(b);
					r.out_valid = 1'b1;
					r.out_byte = b;
					lit_left--;
					if (lit_left == 0)
						end_literal_run();
				end
				PH_OFF0: begin
					n_in++;
					match_dist = {24'd0, b};
					dec_phase = PH_OFF1;
				end
				PH_OFF1: begin
					n_in++;
					match_dist = {16'd0, b, match_dist[7:0]};
					if (match_dist == 0 || match_dist > n_out) begin
						flag_error(n_in);
					end else begin
						mlen_left = tok_match;
						if (tok_match == NIB_EXT)
							dec_phase = PH_MATCHEXT;
						else
							arm_match();
					end
				end
				PH_MATCHEXT: begin
					if (lim_in - n_in <= EXT_TAIL) begin
						flag_error(n_in);
					end else begin
						n_in++;
						if (mlen_left > WORD_MAX - b) begin
							flag_error(n_in);
						end else begin
							mlen_left += b;
							if (b != EXT_MORE)
								arm_match();
						end
					end
				end
				default: ;
			endcase
		end else if (op == OP_PULL && dec_phase == PH_MATCH) begin
			// copy from history, overlap allowed
			r.accepted = 1'b1;
			rd = n_out[15:0] - match_dist[15:0];
			r.out_byte = history_mem[rd];
			r.out_valid = 1'b1;
			store_byte(r.out_byte);
			mlen_left--;
			if (mlen_left == 0)
				dec_phase = PH_TOKEN;
		end
		r.match_pending = (dec_phase == PH_MATCH);
		if (dec_phase == PH_DONE)
			r.status = ST_DONE;
		else if (dec_phase == PH_ERROR)
			r.status = ST_ERROR;
		else
			r.status = ST_DECODING;
		r.out_count = n_out[23:0];
		r.error_position = (dec_phase == PH_ERROR) ? err_pos[23:0] : '0;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s expected %0d got %0d", name, want, got);
		end
	endfunction

	// result checker
	always @(posedge clk) begin : check_results
		dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decode_results_q.size() == 0) begin
				mismatches++;
				$error("result with no request outstanding");
			end else begin
				want = decode_results_q.pop_front();
				compare_field("accepted", 32'(want.accepted), 32'(m_tuser[0]));
				compare_field("out_valid", 32'(want.out_valid), 32'(m_tuser[1]));
				compare_field("match_pending", 32'(want.match_pending), 32'(m_tuser[2]));
				compare_field("status", 32'(want.status), 32'(m_tuser[4:3]));
				compare_field("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
				compare_field("out_count", 32'(want.out_count), 32'(m_tdata[31:8]));
				compare_field("error_position", 32'(want.error_position),
					32'(m_tdata[55:32]));
			end
		end
	end

	// result ready: random stalls, plus a long hold when the test asks for one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_served <= 0;
			hold_left <= 0;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !gaps_on || ($urandom_range(99) >= 11);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_lz4_block_decompressor NOT OK");
			$finish;
		end
	end

	// offer one request, wait for it to be taken, record its expected result
	task automatic send_req(input logic [1:0] op, input logic [7:0] b);
		if (gaps_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_results_q.push_back(decode_request(op, b));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (decode_results_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_BLOCK_LENGTH)
			cfg_len = val;
		else
			cfg_cap = val;
	endtask

	// occasional request that the block should refuse
	task automatic maybe_noise();
		if ($urandom_range(99) < 5) begin
			if ($urandom_range(1))
				send_req(OP_BAD, 8'($urandom_range(255)));
			else if (dec_phase == PH_MATCH)
				send_req(OP_PUSH, 8'($urandom_range(255)));
			else
				send_req(OP_PULL, 8'($urandom_range(255)));
		end
	endtask

	task automatic push_length_ext(input int rem);
		while (rem >= 255) begin
			blk_bytes.push_back(EXT_MORE);
			rem -= 255;
		end
		blk_bytes.push_back(rem[7:0]);
	endtask

	// well-formed block: a few sequences, last one literals only
	task automatic build_block(output int produced);
		int nseq, lits, mlen, offs, reach;
		bit last;
		logic [3:0] lit_nib, match_nib;
		blk_bytes.delete();
		produced = 0;
		nseq = $urandom_range(3);
		for (int s = 0; s <= nseq; s++) begin
			last = (s == nseq);
			if (last)
				lits = $urandom_range(12, 6);
			else if ($urandom_range(39) == 0)
				lits = 270 + $urandom_range(3);
			else if ($urandom_range(7) == 0)
				lits = $urandom_range(22, 15);
			else
				lits = $urandom_range(6);
			if (!last && produced + lits == 0)
				lits = 1;
			if ($urandom_range(59) == 0)
				mlen = 274 + $urandom_range(3);
			else if ($urandom_range(7) == 0)
				mlen = $urandom_range(24, 19);
			else
				mlen = $urandom_range(10, 4);
			lit_nib = (lits >= 15) ? NIB_EXT : lits[3:0];
			match_nib = last ? 4'h0 : ((mlen - 4 >= 15) ? NIB_EXT : 4'(mlen - 4));
			blk_bytes.push_back({lit_nib, match_nib});
			if (lits >= 15)
				push_length_ext(lits - 15);
			repeat (lits) blk_bytes.push_back(8'($urandom_range(255)));
			produced += lits;
			if (!last) begin
				// mostly short distances so copies overlap
				reach = (produced > 65535) ? 65535 : produced;
				if ($urandom_range(1) && reach > 8)
					reach = 8;
				offs = $urandom_range(reach, 1);
				blk_bytes.push_back(offs[7:0]);
				blk_bytes.push_back(offs[15:8]);
				if (mlen - 4 >= 15)
					push_length_ext(mlen - 19);
				produced += mlen;
			end
		end
	endtask

	// configure, start and stream one block, pulling match bytes as they become pending
	task automatic run_block(input bit allow_broken);
		int produced, nsend, len, cap;
		build_block(produced);
		len = blk_bytes.size();
		nsend = len;
		case ($urandom_range(19))
			0: cap = LEN_MAX;
			1, 2: cap = $urandom_range(LEN_MAX);
			3, 4, 5, 6, 7, 8: cap = produced + $urandom_range(300, 1);
			default: cap = produced;
		endcase
		if (allow_broken && $urandom_range(3) == 0) begin
			case ($urandom_range(4))
				0: blk_bytes[$urandom_range(len - 1)] = 8'($urandom_range(255));
				1: len = len - $urandom_range(3, 1);
				2: len = len + $urandom_range(9, 1);
				3: cap = produced - $urandom_range(6, 1);
				default: nsend = $urandom_range(len - 1, 1);
			endcase
		end
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, len[23:0]);
		write_reg(REG_OUTPUT_CAPACITY, cap[23:0]);
		send_req(OP_START, 8'($urandom_range(255)));
		for (int i = 0; i < nsend && !(dec_phase inside {PH_DONE, PH_ERROR}); i++) begin
			while (dec_phase == PH_MATCH) begin
				maybe_noise();
				send_req(OP_PULL, 8'($urandom_range(255)));
				work_items++;
			end
			maybe_noise();
			send_req(OP_PUSH, blk_bytes[i]);
			work_items++;
		end
		while (dec_phase == PH_MATCH) begin
			send_req(OP_PULL, 8'($urandom_range(255)));
			work_items++;
		end
	endtask

	// zero capacity blocks, and requests refused while idle or finished
	task automatic test_zero_capacity();
		write_reg(REG_OUTPUT_CAPACITY, 24'd0);
		write_reg(REG_BLOCK_LENGTH, 24'd1);
		send_req(OP_PUSH, 8'hFF);
		send_req(OP_PULL, 8'h00);
		send_req(OP_BAD, 8'hA5);
		send_req(OP_START, 8'h00);
		send_req(OP_PUSH, 8'h00);
		send_req(OP_PUSH, 8'h11);
		send_req(OP_START, 8'hFF);
		send_req(OP_PUSH, 8'h80);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, 24'd2);
		send_req(OP_START, 8'h00);
		wait_drained();
	endtask

	// empty block, then largest limits with a distance beyond the output
	task automatic test_empty_and_extremes();
		write_reg(REG_BLOCK_LENGTH, 24'd0);
		write_reg(REG_OUTPUT_CAPACITY, LEN_MAX);
		send_req(OP_START, 8'h00);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, LEN_MAX);
		send_req(OP_START, 8'h00);
		send_req(OP_PUSH, 8'h00);
		send_req(OP_PUSH, 8'hFF);
		send_req(OP_PUSH, 8'hFF);
		wait_drained();
	endtask

	// distance-one match with refused push and pull around it, clean end
	task automatic test_overlap_match();
		write_reg(REG_BLOCK_LENGTH, 24'd12);
		write_reg(REG_OUTPUT_CAPACITY, 24'd12);
		send_req(OP_START, 8'h00);
		send_req(OP_PUSH, 8'h20);
		send_req(OP_PUSH, 8'h00);
		send_req(OP_PUSH, 8'hFF);
		send_req(OP_PUSH, 8'h01);
		send_req(OP_PUSH, 8'h00);
		send_req(OP_PUSH, 8'h77);
		repeat (4) send_req(OP_PULL, 8'h00);
		send_req(OP_PULL, 8'h00);
		send_req(OP_PUSH, 8'h60);
		repeat (6) send_req(OP_PUSH, 8'($urandom_range(255)));
		wait_drained();
	endtask

	task automatic test_random_blocks(input int quota);
		work_items = 0;
		while (work_items < quota)
			run_block(1'b1);
	endtask

	// stretch with no idling on either side
	task automatic test_steady_stream(input int quota);
		gaps_on <= 1'b0;
		work_items = 0;
		while (work_items < quota)
			run_block(1'b1);
		wait_drained();
		gaps_on <= 1'b1;
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_stall();
		wait_drained();
		hold_asked <= hold_asked + 1;
		run_block(1'b0);
		run_block(1'b0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_capacity();
		test_empty_and_extremes();
		test_overlap_match();
		test_random_blocks(380);
		test_steady_stream(110);
		test_output_stall();
		wait_drained();
		if (mismatches == 0)
			$display("tb_lz4_block_decompressor OK");
		else
			$display("tb_lz4_block_decompressor NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lz4d_pkg.sv
rtl/lz4d_parser.sv
rtl/lz4_block_decompressor.sv
rtl/lz4d_checker.sv
tb/tb_lz4_block_decompressor.sv
